// File: hdl/rsas_pkg.sv
package rsas_pkg;

   // Input and result beats.
   typedef struct packed {
      logic [7:0] char_code;
      logic       second_operand;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic [1:0] error_code;
      logic       last_out;
   } rsp_type;

   // Character codes.
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_O     = 8'h6F;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [4:0] DIGIT_BAD = 5'd16;
   localparam logic [3:0] RADIX_TEN = 4'd10;

   // Operand formats; the same codes select the output radix.
   localparam logic [2:0] FMT_BIN     = 3'd0;
   localparam logic [2:0] FMT_OCT     = 3'd1;
   localparam logic [2:0] FMT_HEX     = 3'd2;
   localparam logic [2:0] FMT_DEC     = 3'd3;
   localparam logic [2:0] FMT_INVALID = 3'd4;

   localparam logic [1:0] RADIX_BIN = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;
   localparam logic [1:0] RADIX_DEC = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_FORMAT = 2'd1;
   localparam logic [1:0] ERR_DIGIT  = 2'd2;
   localparam logic [1:0] ERR_WIDTH  = 2'd3;

   // Parse phases.
   localparam logic [1:0] PH_START  = 2'd0;
   localparam logic [1:0] PH_LETTER = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;

   // Register indexes.
   localparam logic CSR_SUBTRACT = 1'b0;
   localparam logic CSR_RADIX    = 1'b1;

   typedef enum logic [1:0] {
      SEL_ERR,
      SEL_SIGN,
      SEL_LETTER,
      SEL_DIGIT
   } emit_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         accept;
      logic         clear;
      logic         len_load;
      logic         len_step;
      logic         len_set;
      logic         prep;
      logic         sum;
      logic         sign;
      logic         dd_init;
      logic         dd_step;
      logic         dig_next;
      logic         emit;
      emit_sel_type emit_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic len_done;
      logic dabble_done;
      logic err_present;
      logic r_negative;
      logic radix_dec;
      logic digit_last;
      logic digit_skip;
      logic out_free;
   } status_type;

   function automatic logic [2:0] letter_format(input logic [7:0] c);
      logic [2:0] f;
      case (c)
         CH_B:    f = FMT_BIN;
         CH_O:    f = FMT_OCT;
         CH_X:    f = FMT_HEX;
         CH_D:    f = FMT_DEC;
         default: f = FMT_INVALID;
      endcase
      return f;
   endfunction

   // Digit value in the given format, or DIGIT_BAD.
   function automatic logic [4:0] digit_value(input logic [7:0] c, input logic [2:0] fmt);
      logic [4:0] v;
      v = DIGIT_BAD;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = 5'(c - CH_ZERO);
      end else if (c >= CH_LA && c <= CH_LF) begin
         v = 5'(c - CH_LA) + 5'(RADIX_TEN);
      end else if (c >= CH_UA && c <= CH_UF) begin
         v = 5'(c - CH_UA) + 5'(RADIX_TEN);
      end
      if (fmt == FMT_BIN && v > 5'd1) begin
         v = DIGIT_BAD;
      end
      if (fmt == FMT_OCT && v > 5'd7) begin
         v = DIGIT_BAD;
      end
      if (fmt == FMT_DEC && v > 5'd9) begin
         v = DIGIT_BAD;
      end
      return v;
   endfunction

endpackage

// File: hdl/radix_string_add_subtract_top.sv
// Sequence: after the final character of the second operand, a load state, a bit-length
// scan, length set, prep, sum and sign steps, for decimal output a double-dabble pass,
// then one result beat per cycle while the output side is ready; a positive sign slot
// and each leading decimal zero are passed over without a beat. On an error the load
// state goes straight to the error state, which loads the error beat instead of a scan.
// Throughput: one character per cycle while idle; none during a run. Synchronous reset.
module radix_string_add_subtract_top
   import rsas_pkg::*;
#(
   parameter int OPERAND_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       req_final;

   // The final character of the second operand starts a run.
   assign req_final = req_data.last_char && req_data.second_operand;

   rsas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_final (req_final),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rsas_datapath #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/rsas_ctrl.sv
module rsas_ctrl
   import rsas_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_final,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_LENLD   = 13'b0000000000010,
      ST_BITLEN  = 13'b0000000000100,
      ST_LSET    = 13'b0000000001000,
      ST_PREP    = 13'b0000000010000,
      ST_SUM     = 13'b0000000100000,
      ST_SIGN    = 13'b0000001000000,
      ST_DDINIT  = 13'b0000010000000,
      ST_DABBLE  = 13'b0000100000000,
      ST_OSIGN   = 13'b0001000000000,
      ST_OLETTER = 13'b0010000000000,
      ST_ODIGIT  = 13'b0100000000000,
      ST_OERR    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.emit_sel = SEL_ERR;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && req_final) begin
               state_in = ST_LENLD;
            end
         end
         ST_LENLD: begin
            cmd.len_load = 1'b1;
            state_in = status.err_present ? ST_OERR : ST_BITLEN;
         end
         ST_BITLEN: begin
            cmd.len_step = 1'b1;
            if (status.len_done) begin
               state_in = ST_LSET;
            end
         end
         ST_LSET: begin
            cmd.len_set = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            state_in = ST_SIGN;
         end
         ST_SIGN: begin
            cmd.sign = 1'b1;
            state_in = status.radix_dec ? ST_DDINIT : ST_OSIGN;
         end
         ST_DDINIT: begin
            cmd.dd_init = 1'b1;
            state_in = ST_DABBLE;
         end
         ST_DABBLE: begin
            if (status.dabble_done) begin
               state_in = ST_OSIGN;
            end else begin
               cmd.dd_step = 1'b1;
            end
         end
         ST_OSIGN: begin
            cmd.emit_sel = SEL_SIGN;
            if (!status.r_negative) begin
               state_in = ST_OLETTER;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_OLETTER;
            end
         end
         ST_OLETTER: begin
            cmd.emit_sel = SEL_LETTER;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_ODIGIT;
            end
         end
         ST_ODIGIT: begin
            cmd.emit_sel = SEL_DIGIT;
            if (status.digit_skip) begin
               cmd.dig_next = 1'b1;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.digit_last) begin
                  cmd.clear = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.dig_next = 1'b1;
               end
            end
         end
         ST_OERR: begin
            cmd.emit_sel = SEL_ERR;
            if (status.out_free) begin
               cmd.emit  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // A finished second operand always starts the computation.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_final) |=> (state_ff == ST_LENLD))
      else $error("computation did not start");

   // A result beat is only loaded into a free output register.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result beat overwritten");

   // No new characters are taken while a run is in progress.
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !cmd.accept)
      else $error("character accepted during a run");

   // The final digit closes the run.
   a_close: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_sel == SEL_DIGIT && status.digit_last) |=> req_ready)
      else $error("run not closed after last digit");
`endif

endmodule

// File: hdl/rsas_datapath.sv
module rsas_datapath
   import rsas_pkg::*;
#(
   parameter int OPERAND_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [1:0] csr_wdata,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int W  = OPERAND_BITS + 2;
   localparam int LW = $clog2(W + 1);
   localparam int D  = (W * 30103) / 100000 + 1;
   localparam int BW = 4 * D;

   // Configuration.
   logic       subtract_ff;
   logic [1:0] radix_ff;

   // Operand state, index 0 first operand, 1 second.
   logic [W-1:0]  val_ff [2];
   logic [W-1:0]  val_in [2];
   logic [LW-1:0] len_ff [2];
   logic [LW-1:0] len_in [2];
   logic          neg_ff [2];
   logic          neg_in [2];
   logic [2:0]    fmt_ff [2];
   logic [2:0]    fmt_in [2];
   logic [1:0]    phase_ff, phase_in;
   logic [1:0]    pend_ff, pend_in;

   // Computation state.
   logic [W-1:0]  sa_ff, sb_ff;
   logic [LW-1:0] ca_ff, cb_ff;
   logic [LW-1:0] lres_ff;
   logic [W-1:0]  a_ff, b_ff, r_ff;
   logic          rneg_ff;
   logic [BW-1:0] bcd_ff;
   logic [W-1:0]  shr_ff;
   logic [LW-1:0] dcnt_ff;
   logic [LW-1:0] dig_ff;
   logic          started_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   // Parse signals.
   logic            sel;
   logic [7:0]      c;
   logic [W-1:0]    cur_val;
   logic [LW-1:0]   cur_len;
   logic [2:0]      cur_fmt;
   logic [4:0]      dval_in;
   logic [W+3:0]    nv_dec;
   logic [2:0]      bpd;
   logic            len_over;
   logic            note;
   logic [1:0]      note_code;

   always_comb begin
      sel      = req_data.second_operand;
      c        = req_data.char_code;
      cur_val  = val_ff[sel];
      cur_len  = len_ff[sel];
      cur_fmt  = fmt_ff[sel];
      dval_in  = digit_value(c, cur_fmt);
      nv_dec   = (W+4)'({cur_val, 3'b000}) + (W+4)'({cur_val, 1'b0}) + (W+4)'(dval_in);
      bpd      = (cur_fmt == FMT_BIN) ? 3'd1 : (cur_fmt == FMT_OCT) ? 3'd3 : 3'd4;
      len_over = ((LW+1)'(cur_len) + (LW+1)'(bpd)) > (LW+1)'(OPERAND_BITS + 2);
      note      = 1'b0;
      note_code = ERR_NONE;
      phase_in = phase_ff;
      pend_in  = pend_ff;
      val_in   = val_ff;
      len_in   = len_ff;
      neg_in   = neg_ff;
      fmt_in   = fmt_ff;
      if (cmd.clear) begin
         phase_in = PH_START;
         pend_in  = ERR_NONE;
         for (int i = 0; i < 2; i++) begin
            val_in[i] = '0;
            len_in[i] = LW'(2);
            neg_in[i] = 1'b0;
            fmt_in[i] = FMT_INVALID;
         end
      end else if (cmd.accept) begin
         case (phase_ff)
            PH_START: begin
               val_in[sel] = '0;
               len_in[sel] = LW'(2);
               neg_in[sel] = 1'b0;
               fmt_in[sel] = FMT_INVALID;
               if (c == CH_MINUS) begin
                  neg_in[sel] = 1'b1;
                  phase_in    = PH_LETTER;
               end else begin
                  fmt_in[sel] = letter_format(c);
                  phase_in    = PH_DIGITS;
               end
            end
            PH_LETTER: begin
               fmt_in[sel] = letter_format(c);
               phase_in    = PH_DIGITS;
            end
            default: begin
               if (!cur_fmt[2]) begin
                  if (dval_in == DIGIT_BAD) begin
                     note      = 1'b1;
                     note_code = ERR_DIGIT;
                  end else if (cur_fmt == FMT_DEC) begin
                     if (nv_dec[W+3:OPERAND_BITS] != '0) begin
                        note      = 1'b1;
                        note_code = ERR_WIDTH;
                     end else begin
                        val_in[sel] = nv_dec[W-1:0];
                     end
                  end else if (len_over) begin
                     note      = 1'b1;
                     note_code = ERR_WIDTH;
                  end else begin
                     val_in[sel] = (cur_val << bpd) | W'(dval_in[3:0]);
                     len_in[sel] = cur_len + LW'(bpd);
                  end
               end
            end
         endcase
         if (note && (pend_ff == ERR_NONE || note_code < pend_ff)) begin
            pend_in = note_code;
         end
         if (req_data.last_char) begin
            phase_in = PH_START;
         end
      end
   end

   // Operand registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         pend_ff     <= ERR_NONE;
         val_ff      <= '{default: '0};
         len_ff      <= '{default: LW'(2)};
         neg_ff      <= '{default: 1'b0};
         fmt_ff      <= '{default: FMT_INVALID};
         subtract_ff <= 1'b0;
         radix_ff    <= RADIX_DEC;
      end else begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         val_ff   <= val_in;
         len_ff   <= len_in;
         neg_ff   <= neg_in;
         fmt_ff   <= fmt_in;
         if (csr_we && csr_index == CSR_SUBTRACT) begin
            subtract_ff <= csr_wdata[0];
         end
         if (csr_we && csr_index == CSR_RADIX) begin
            radix_ff <= csr_wdata;
         end
      end
   end

   // Common length, mask and operand lengths.
   logic [LW-1:0] la, lb;
   logic [W-1:0]  mask;
   logic [W-1:0]  sum_raw;
   logic [W-1:0]  r_neg_val;
   logic [LW:0]   cnt_out;

   always_comb begin
      la = (fmt_ff[0] == FMT_DEC) ? ca_ff + LW'(2) : len_ff[0];
      lb = (fmt_ff[1] == FMT_DEC) ? cb_ff + LW'(2) : len_ff[1];
      for (int i = 0; i < W; i++) begin
         mask[i] = (LW'(i) < lres_ff);
      end
      sum_raw   = subtract_ff ? a_ff - b_ff : a_ff + b_ff;
      r_neg_val = (W'(0) - r_ff) & mask;
      // The octal digit count divides by three through a reciprocal multiplication.
      case (radix_ff)
         RADIX_BIN: cnt_out = (LW+1)'(lres_ff);
         RADIX_OCT: cnt_out = (LW+1)'((((LW+9)'(lres_ff) + (LW+9)'(2)) * (LW+9)'(171)) >> 9);
         RADIX_HEX: cnt_out = ((LW+1)'(lres_ff) + (LW+1)'(3)) >> 2;
         default:   cnt_out = (LW+1)'(D);
      endcase
   end

   // Double-dabble adjust of every decimal digit.
   logic [BW-1:0] bcd_adj;

   always_comb begin
      for (int k = 0; k < D; k++) begin
         bcd_adj[4*k +: 4] = (bcd_ff[4*k +: 4] >= 4'd5) ? bcd_ff[4*k +: 4] + 4'd3
                                                         : bcd_ff[4*k +: 4];
      end
   end

   // Computation sequence.
   always_ff @(posedge clock) begin
      if (cmd.len_load) begin
         sa_ff <= val_ff[0];
         sb_ff <= val_ff[1];
         ca_ff <= '0;
         cb_ff <= '0;
      end else if (cmd.len_step) begin
         if (sa_ff != '0) begin
            sa_ff <= sa_ff >> 1;
            ca_ff <= ca_ff + LW'(1);
         end
         if (sb_ff != '0) begin
            sb_ff <= sb_ff >> 1;
            cb_ff <= cb_ff + LW'(1);
         end
      end
      if (cmd.len_set) begin
         lres_ff <= (la > lb) ? la : lb;
      end
      if (cmd.prep) begin
         a_ff <= neg_ff[0] ? (W'(0) - val_ff[0]) & mask : val_ff[0];
         b_ff <= neg_ff[1] ? (W'(0) - val_ff[1]) & mask : val_ff[1];
      end
      if (cmd.sum) begin
         r_ff <= sum_raw & mask;
      end
      if (cmd.sign) begin
         rneg_ff <= r_ff[LW'(lres_ff - LW'(1))];
         if (r_ff[LW'(lres_ff - LW'(1))]) begin
            r_ff <= r_neg_val;
         end
         dig_ff <= LW'(cnt_out - (LW+1)'(1));
      end else if (cmd.dig_next) begin
         dig_ff <= dig_ff - LW'(1);
      end
      if (cmd.dd_init) begin
         bcd_ff  <= '0;
         shr_ff  <= r_ff;
         dcnt_ff <= '0;
      end else if (cmd.dd_step) begin
         bcd_ff  <= {bcd_adj[BW-2:0], shr_ff[W-1]};
         shr_ff  <= shr_ff << 1;
         dcnt_ff <= dcnt_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.sign) begin
         started_ff <= 1'b0;
      end else if (cmd.emit && cmd.emit_sel == SEL_DIGIT) begin
         started_ff <= 1'b1;
      end
   end

   // Current output digit.
   logic [2:0]    bpd_out;
   logic [W-1:0]  r_shift;
   logic [BW-1:0] bcd_shift;
   logic [3:0]    dig_val;
   logic [7:0]    dig_char;
   logic [7:0]    letter;
   logic [1:0]    err_now;

   always_comb begin
      case (radix_ff)
         RADIX_BIN: bpd_out = 3'd1;
         RADIX_OCT: bpd_out = 3'd3;
         default:   bpd_out = 3'd4;
      endcase
      r_shift   = r_ff >> ((LW+3)'(dig_ff) * (LW+3)'(bpd_out));
      bcd_shift = bcd_ff >> {dig_ff, 2'b00};
      case (radix_ff)
         RADIX_BIN: dig_val = {3'b000, r_shift[0]};
         RADIX_OCT: dig_val = {1'b0, r_shift[2:0]};
         RADIX_HEX: dig_val = r_shift[3:0];
         default:   dig_val = bcd_shift[3:0];
      endcase
      dig_char = (dig_val < RADIX_TEN) ? CH_ZERO + 8'(dig_val)
                                       : CH_UA + 8'(dig_val) - 8'(RADIX_TEN);
      case (radix_ff)
         RADIX_BIN: letter = CH_B;
         RADIX_OCT: letter = CH_O;
         RADIX_HEX: letter = CH_X;
         default:   letter = CH_D;
      endcase
      err_now = (fmt_ff[0][2] || fmt_ff[1][2]) ? ERR_FORMAT : pend_ff;
   end

   // Output register for the result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         case (cmd.emit_sel)
            SEL_ERR:    rsp_data_ff <= '{out_char: 8'h00, error_code: err_now, last_out: 1'b1};
            SEL_SIGN:   rsp_data_ff <= '{out_char: CH_MINUS, error_code: ERR_NONE,
                                         last_out: 1'b0};
            SEL_LETTER: rsp_data_ff <= '{out_char: letter, error_code: ERR_NONE,
                                         last_out: 1'b0};
            default:    rsp_data_ff <= '{out_char: dig_char, error_code: ERR_NONE,
                                         last_out: (dig_ff == '0)};
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status to the controller.
   always_comb begin
      status.len_done    = (sa_ff == '0) && (sb_ff == '0);
      status.dabble_done = (dcnt_ff == LW'(W));
      status.err_present = (err_now != ERR_NONE);
      status.r_negative  = rneg_ff;
      status.radix_dec   = (radix_ff == RADIX_DEC);
      status.digit_last  = (dig_ff == '0);
      status.digit_skip  = (radix_ff == RADIX_DEC) && !started_ff && (dig_ff != '0) &&
                           (dig_val == 4'd0);
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

endmodule

// File: tb/tb_radix_string_add_subtract_top.sv
module tb_radix_string_add_subtract_top
   import rsas_pkg::*;
();

   localparam int OPERAND_BITS = 32;
   localparam int IDLE_LIMIT   = 20000;
   localparam int SETTLE       = 120;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic       csr_index = 1'b0;
   logic [1:0] csr_wdata = 2'b00;

   radix_string_add_subtract_top #(.OPERAND_BITS(OPERAND_BITS)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: the two operands, the parse position and the registers.
   logic [63:0] op_val [2];
   int          op_len [2];
   bit          op_neg [2];
   logic [2:0]  op_fmt [2];
   logic [1:0]  parse_pos;
   logic [1:0]  first_error;
   bit          subtract_on;
   logic [1:0]  out_radix;

   rsp_type     expected_chars [$];
   logic [7:0]  op_buf [$];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_cycles = 0;
   int sent_count = 0;
   int result_count = 0;
   int run_count = 0;
   int mismatch_count = 0;
   int idle_count = 0;

   function automatic logic [7:0] format_char(input logic [2:0] f);
      case (f)
         FMT_BIN: return CH_B;
         FMT_OCT: return CH_O;
         FMT_HEX: return CH_X;
         default: return CH_D;
      endcase
   endfunction

   function automatic logic [2:0] char_format(input logic [7:0] c);
      if (c == CH_B) return FMT_BIN;
      if (c == CH_O) return FMT_OCT;
      if (c == CH_X) return FMT_HEX;
      if (c == CH_D) return FMT_DEC;
      return FMT_INVALID;
   endfunction

   // Digit value of a character, or -1 if the format does not allow it.
   function automatic int char_digit(input logic [7:0] c, input logic [2:0] f);
      int v;
      v = -1;
      if (c >= "0" && c <= "9") v = c - "0";
      else if (c >= "a" && c <= "f") v = c - "a" + 10;
      else if (c >= "A" && c <= "F") v = c - "A" + 10;
      if (f == FMT_BIN && v > 1) v = -1;
      if (f == FMT_OCT && v > 7) v = -1;
      if (f == FMT_DEC && v > 9) v = -1;
      return v;
   endfunction

   function automatic int bits_of(input logic [2:0] f);
      return (f == FMT_BIN) ? 1 : (f == FMT_OCT) ? 3 : 4;
   endfunction

   function automatic int bit_count(input logic [63:0] v);
      int n;
      n = 0;
      while (v != 0) begin
         v = v >> 1;
         n++;
      end
      return n;
   endfunction

   function automatic void note_error(input logic [1:0] code);
      if (first_error == ERR_NONE || code < first_error) first_error = code;
   endfunction

   function automatic void clear_operand(input bit s);
      op_val[s] = '0;
      op_len[s] = 2;
      op_neg[s] = 1'b0;
      op_fmt[s] = FMT_INVALID;
   endfunction

   function automatic void clear_all();
      clear_operand(1'b0);
      clear_operand(1'b1);
      parse_pos = PH_START;
      first_error = ERR_NONE;
   endfunction

   // Adds one digit to an operand, with the bad digit and width checks.
   function automatic void add_digit(input bit s, input logic [7:0] c);
      int d;
      int bpd;
      logic [63:0] nv;
      if (op_fmt[s] == FMT_INVALID) return;
      d = char_digit(c, op_fmt[s]);
      if (d < 0) begin
         note_error(ERR_DIGIT);
         return;
      end
      if (op_fmt[s] == FMT_DEC) begin
         nv = op_val[s] * 10 + 64'(d);
         if (nv > (64'd1 << OPERAND_BITS) - 1) note_error(ERR_WIDTH);
         else op_val[s] = nv;
         return;
      end
      bpd = bits_of(op_fmt[s]);
      if (op_len[s] - 2 + bpd > OPERAND_BITS) begin
         note_error(ERR_WIDTH);
         return;
      end
      op_val[s] = (op_val[s] << bpd) | 64'(d);
      op_len[s] += bpd;
   endfunction

   // Works out the whole result run once the second operand is complete.
   function automatic void predict_run();
      rsp_type     run [$];
      logic [1:0]  err;
      int          la, lb, width, bpd, cnt, d;
      logic [63:0] mask, a, b, r;
      logic [7:0]  dec [$];
      if (op_fmt[0] == FMT_INVALID || op_fmt[1] == FMT_INVALID) err = ERR_FORMAT;
      else err = first_error;
      if (err != ERR_NONE) begin
         run.push_back(rsp_type'{out_char: 8'h00, error_code: err, last_out: 1'b1});
      end else begin
         la = (op_fmt[0] == FMT_DEC) ? bit_count(op_val[0]) + 2 : op_len[0];
         lb = (op_fmt[1] == FMT_DEC) ? bit_count(op_val[1]) + 2 : op_len[1];
         width = (la > lb) ? la : lb;
         mask = (64'd1 << width) - 1;
         a = op_neg[0] ? (-op_val[0]) & mask : op_val[0];
         b = op_neg[1] ? (-op_val[1]) & mask : op_val[1];
         r = (subtract_on ? a - b : a + b) & mask;
         if (r[width-1]) begin
            run.push_back(rsp_type'{out_char: CH_MINUS, error_code: ERR_NONE, last_out: 1'b0});
            r = (-r) & mask;
         end
         run.push_back(rsp_type'{out_char: format_char({1'b0, out_radix}),
                                 error_code: ERR_NONE, last_out: 1'b0});
         if (out_radix == RADIX_DEC) begin
            do begin
               dec.push_front(8'("0" + (r % 10)));
               r = r / 10;
            end while (r != 0);
            foreach (dec[i])
               run.push_back(rsp_type'{out_char: dec[i], error_code: ERR_NONE, last_out: 1'b0});
         end else begin
            bpd = bits_of({1'b0, out_radix});
            cnt = (width + bpd - 1) / bpd;
            for (int i = cnt - 1; i >= 0; i--) begin
               d = int'((r >> (i * bpd)) & ((64'd1 << bpd) - 1));
               run.push_back(rsp_type'{out_char: (d < 10) ? 8'("0" + d) : 8'("A" + d - 10),
                                       error_code: ERR_NONE, last_out: 1'b0});
            end
         end
         run[run.size()-1].last_out = 1'b1;
      end
      foreach (run[i]) expected_chars.push_back(run[i]);
      run_count++;
      clear_all();
   endfunction

   function automatic void predict_char(input req_type it);
      bit s;
      s = it.second_operand;
      if (parse_pos == PH_START) begin
         clear_operand(s);
         if (it.char_code == CH_MINUS) begin
            op_neg[s] = 1'b1;
            parse_pos = PH_LETTER;
         end else begin
            op_fmt[s] = char_format(it.char_code);
            parse_pos = PH_DIGITS;
         end
      end else if (parse_pos == PH_LETTER) begin
         op_fmt[s] = char_format(it.char_code);
         parse_pos = PH_DIGITS;
      end else begin
         add_digit(s, it.char_code);
      end
      if (it.last_char) begin
         parse_pos = PH_START;
         if (s) predict_run();
      end
   endfunction

   // Input monitor: each accepted beat updates the prediction.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) predict_char(req_data);
   end

   // Result checker: each accepted beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (expected_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result beat: char %h error %0d last %b",
                        rsp_data.out_char, rsp_data.error_code, rsp_data.last_out);
         end else begin
            if (rsp_data.out_char !== expected_chars[0].out_char ||
                rsp_data.error_code !== expected_chars[0].error_code ||
                rsp_data.last_out !== expected_chars[0].last_out) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected char %h error %0d last %b, got char %h error %0d last %b",
                           expected_chars[0].out_char, expected_chars[0].error_code,
                           expected_chars[0].last_out, rsp_data.out_char,
                           rsp_data.error_code, rsp_data.last_out);
            end
            void'(expected_chars.pop_front());
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_char(input logic [7:0] c, input bit s, input bit last);
      req_valid <= 1'b1;
      req_data <= req_type'{char_code: c, second_operand: s, last_char: last};
      do @(posedge clock); while (!req_ready);
      sent_count++;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_buf(input bit s);
      foreach (op_buf[i]) send_char(op_buf[i], s, i == op_buf.size() - 1);
   endtask

   task automatic send_text(input bit s, input string txt);
      op_buf.delete();
      for (int i = 0; i < txt.len(); i++) op_buf.push_back(txt[i]);
      send_buf(s);
   endtask

   task automatic send_pair(input string first, input string second);
      send_text(1'b0, first);
      send_text(1'b1, second);
   endtask

   // Waits for all results, then lets the block settle before any register write.
   // The first edge lets the monitor record the last accepted beat.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SUBTRACT) subtract_on = value[0];
      else out_radix = value;
   endtask

   // A well-formed operand with random sign, format and digits, now and then
   // too long or with a stray character.
   task automatic make_operand();
      logic [2:0] f;
      int n, lim, d;
      op_buf.delete();
      f = 3'($urandom_range(3));
      if ($urandom_range(2) == 0) op_buf.push_back(CH_MINUS);
      op_buf.push_back(format_char(f));
      lim = (f == FMT_BIN) ? 34 : (f == FMT_OCT) ? 12 : (f == FMT_HEX) ? 10 : 11;
      n = ($urandom_range(5) == 0) ? $urandom_range(lim) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(24) == 0) begin
            op_buf.push_back(8'($urandom_range(255)));
         end else begin
            d = $urandom_range((f == FMT_BIN) ? 1 : (f == FMT_OCT) ? 7 : (f == FMT_HEX) ? 15 : 9);
            if (d < 10) op_buf.push_back(8'("0" + d));
            else if ($urandom_range(1)) op_buf.push_back(8'("a" + d - 10));
            else op_buf.push_back(8'("A" + d - 10));
         end
      end
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++)
         send_char($urandom_range(1) ? 8'($urandom_range(255)) :
                   format_char(3'($urandom_range(4))),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      send_char(8'($urandom_range(255)), 1'b1, 1'b1);
   endtask

   // Zero, signs, upper and lower case hex, the format and digit errors and the shared parse position.
   task automatic test_directed();
      send_pair("d0", "d0");
      send_pair("-xaF", "b1");
      send_pair("q1", "d3");
      send_pair("d1z", "o7");
      send_pair("-9", "d2");
      send_char(CH_D, 1'b0, 1'b0);
      send_char("5", 1'b1, 1'b1);
      send_pair("x1", "-d4");
   endtask

   task automatic test_random(input int chars);
      int stop;
      stop = sent_count + chars;
      while (sent_count < stop) begin
         if ($urandom_range(9) < 8) begin
            make_operand();
            send_buf(1'b0);
            make_operand();
            send_buf(1'b1);
         end else begin
            send_noise();
         end
      end
   endtask

   // Runs with binary, octal and hex operands while the receiver holds off, so the input stalls.
   task automatic test_backpressure();
      hold_cycles = 300;
      send_pair("b111111111", "-b1");
      send_pair("-o7", "x7f");
   endtask

   // Largest decimal magnitudes, a hex operand one digit too wide and a decimal one just too large.
   task automatic test_width_limits();
      send_pair("d4294967295", "-d4294967295");
      send_pair("x123456789", "d4294967296");
   endtask

   initial begin
      subtract_on = 1'b0;
      out_radix = RADIX_DEC;
      clear_all();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 16;
      rx_idle_pct = 55;
      test_directed();
      drain();
      write_reg(CSR_SUBTRACT, 2'd1);
      write_reg(CSR_RADIX, RADIX_BIN);
      test_random(6);
      drain();

      tx_idle_pct = 55;
      rx_idle_pct = 16;
      write_reg(CSR_SUBTRACT, 2'd0);
      write_reg(CSR_RADIX, RADIX_HEX);
      test_random(6);
      drain();
      write_reg(CSR_RADIX, RADIX_OCT);
      write_reg(CSR_SUBTRACT, 2'd1);
      test_backpressure();
      drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_reg(CSR_RADIX, RADIX_DEC);
      test_width_limits();
      test_random(6);
      drain();

      $display("Sent %0d characters in all formats and both modes; %0d result runs,",
               sent_count, run_count);
      $display("%0d result beats checked, %0d mismatches.", result_count, mismatch_count);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
